### hdl/dsc_pkg.sv
// Shared types, field layout and saturation helpers for the delayed sparse coupling block.
package dsc_pkg;

    // input field widths
    localparam int OPCODE_W = 2;
    localparam int TIME_W   = 8;
    localparam int NODE_W   = 10;
    localparam int VAL_W    = 16;
    localparam int WGT_W    = 16;
    localparam int DELAY_W  = 8;

    // input tdata layout, lowest bit first
    localparam int TIME_LSB   = 0;
    localparam int NODE_LSB   = TIME_LSB + TIME_W;
    localparam int SAMPLE_LSB = NODE_LSB + NODE_W;
    localparam int SRC_LSB    = SAMPLE_LSB + VAL_W;
    localparam int WGT_LSB    = SRC_LSB + NODE_W;
    localparam int DELAY_LSB  = WGT_LSB + WGT_W;
    localparam int IN_BITS    = DELAY_LSB + DELAY_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // arithmetic
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int OUT_W       = 32;
    localparam int OUT_TDATA_W = 2 * OUT_W;

    // 1.0 in Q4.12
    localparam logic signed [VAL_W-1:0] HEAVI_ONE = 16'sd4096;

    // result buffer
    localparam int OF_DEPTH = 8;
    localparam int OF_AW    = $clog2(OF_DEPTH);
    localparam int OF_CW    = $clog2(OF_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CONN  = 2'd1,
        OP_EMPTY = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STORE_MODE = 1'b0,
        CFG_THRESHOLD  = 1'b1
    } t_cfg_reg;

    // clamp a grown sum back into the signed accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
        logic signed [ACC_W-1:0] r;
        if (v[ACC_W] != v[ACC_W-1]) begin
            r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            r = v[ACC_W-1:0];
        end
        return r;
    endfunction

    // clamp an accumulator to the signed output range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if ((&v[ACC_W-1:OUT_W-1]) || !(|v[ACC_W-1:OUT_W-1])) begin
            r = v[OUT_W-1:0];
        end else begin
            r = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### hdl/delayed_sparse_coupling.sv
// Delayed sparse coupling engine: ring-buffer node history and two coupling accumulators.
//
// Takes one item per clock when not stalled. A history write reaches the history memory
// from stage 1; a connection term reads the delayed slot and the slot after it through the
// two read ports of that memory in the same stage, so items that follow a write always see
// it. A row's sums go from the transfer of its last term (or of an empty-row item) through
// the stage 1, memory read, product and accumulator registers to an eight-entry result
// buffer; outside the clear, the input stalls only when eight results are owed and not yet
// taken. After reset the history memory is zeroed one entry per cycle, NODES * HIST_DEPTH
// entries (262144 by default), with no item taken; configuration writes are always taken.
module delayed_sparse_coupling #(
    parameter int NODES      = 1024,
    parameter int HIST_DEPTH = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // time_step[7:0], node_index[17:8], sample_value[33:18], source_node[43:34],
    // weight[59:44], delay[67:60], zero[71:68]
    input  logic [dsc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // opcode[1:0]
    input  logic [dsc_pkg::OPCODE_W-1:0]     i_s_axis_tuser,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // coupling_now[31:0], coupling_next[63:32]
    output logic [dsc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int MEM_DEPTH = NODES * HIST_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int SW        = $clog2(HIST_DEPTH);
    localparam int TAB_N     = 2 ** dsc_pkg::TIME_W;
    localparam logic [SW-1:0] SLOT_LAST = SW'(HIST_DEPTH - 1);
    localparam logic [AW-1:0] CLR_LAST  = AW'(MEM_DEPTH - 1);

    // ---------------- configuration ----------------
    logic                                  r_store_mode;
    logic signed [dsc_pkg::VAL_W-1:0]      r_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_mode <= 1'b0;
            r_threshold  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (dsc_pkg::t_cfg_reg'(i_cfg_index))
                dsc_pkg::CFG_STORE_MODE: r_store_mode <= i_cfg_data[0];
                dsc_pkg::CFG_THRESHOLD:  r_threshold  <= i_cfg_data;
            endcase
        end
    end

    // ---------------- history clear after reset ----------------
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------- input decode ----------------
    // slot = value mod HIST_DEPTH, as a constant lookup
    logic [SW-1:0] w_mod_tab [TAB_N];
    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_mod_tab
        assign w_mod_tab[gi] = SW'(gi % HIST_DEPTH);
    end

    logic                                w_in_xfer;
    dsc_pkg::t_opcode                    w_in_op;
    logic [dsc_pkg::TIME_W-1:0]          w_in_time;
    logic [dsc_pkg::NODE_W-1:0]          w_in_wnode;
    logic [dsc_pkg::NODE_W-1:0]          w_in_src;
    logic [dsc_pkg::NODE_W-1:0]          w_in_node;
    logic [dsc_pkg::DELAY_W-1:0]         w_in_delay;
    logic                                w_in_res;
    logic [dsc_pkg::OF_CW-1:0]           r_pend;

    assign w_in_op    = dsc_pkg::t_opcode'(i_s_axis_tuser);
    assign w_in_time  = i_s_axis_tdata[dsc_pkg::TIME_LSB +: dsc_pkg::TIME_W];
    assign w_in_wnode = i_s_axis_tdata[dsc_pkg::NODE_LSB +: dsc_pkg::NODE_W];
    assign w_in_src   = i_s_axis_tdata[dsc_pkg::SRC_LSB +: dsc_pkg::NODE_W];
    assign w_in_delay = i_s_axis_tdata[dsc_pkg::DELAY_LSB +: dsc_pkg::DELAY_W];
    assign w_in_node  = (w_in_op == dsc_pkg::OP_WRITE) ? w_in_wnode : w_in_src;
    assign w_in_res   = (w_in_op == dsc_pkg::OP_EMPTY) ||
                        ((w_in_op == dsc_pkg::OP_CONN) && i_s_axis_tlast);

    // credit check: every owed result has a place in the result buffer
    assign o_s_axis_tready = !r_clr_busy && (r_pend < dsc_pkg::OF_CW'(dsc_pkg::OF_DEPTH));
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- stage 1: registered item, row base ----------------
    logic                              r_s1_valid;
    dsc_pkg::t_opcode                  r_s1_op;
    logic [SW-1:0]                     r_s1_tslot;
    logic [SW-1:0]                     r_s1_dslot;
    logic [AW-1:0]                     r_s1_base;
    logic                              r_s1_ok;
    logic signed [dsc_pkg::VAL_W-1:0]  r_s1_sample;
    logic signed [dsc_pkg::WGT_W-1:0]  r_s1_w;
    logic                              r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_xfer;
        end
        r_s1_op     <= w_in_op;
        r_s1_tslot  <= w_mod_tab[w_in_time];
        r_s1_dslot  <= w_mod_tab[w_in_delay];
        r_s1_base   <= AW'(w_in_node) * AW'(HIST_DEPTH);
        r_s1_ok     <= 32'(w_in_node) < NODES;
        r_s1_sample <= i_s_axis_tdata[dsc_pkg::SAMPLE_LSB +: dsc_pkg::VAL_W];
        r_s1_w      <= i_s_axis_tdata[dsc_pkg::WGT_LSB +: dsc_pkg::WGT_W];
        r_s1_last   <= i_s_axis_tlast;
    end

    // ---------------- stage 2: history memory access ----------------
    logic [SW:0]                       w_diff;
    logic [SW-1:0]                     w_slot_now;
    logic [SW-1:0]                     w_slot_next;
    logic [AW-1:0]                     w_addr_now;
    logic [AW-1:0]                     w_addr_next;
    logic signed [dsc_pkg::VAL_W-1:0]  w_store;
    logic                              w_mem_we;
    logic [AW-1:0]                     w_mem_waddr;
    logic [dsc_pkg::VAL_W-1:0]         w_mem_wdata;

    assign w_diff      = {1'b0, r_s1_tslot} - {1'b0, r_s1_dslot};
    assign w_slot_now  = w_diff[SW] ? SW'(w_diff + (SW+1)'(HIST_DEPTH)) : w_diff[SW-1:0];
    assign w_slot_next = (w_slot_now == SLOT_LAST) ? '0 : w_slot_now + SW'(1);
    assign w_addr_now  = r_s1_base + AW'(w_slot_now);
    assign w_addr_next = r_s1_base + AW'(w_slot_next);

    // heaviside store: strictly above threshold gives 1.0
    assign w_store = r_store_mode ? ((r_s1_sample > r_threshold) ? dsc_pkg::HEAVI_ONE : '0)
                                  : r_s1_sample;

    assign w_mem_we    = r_clr_busy ||
                         (r_s1_valid && (r_s1_op == dsc_pkg::OP_WRITE) && r_s1_ok);
    assign w_mem_waddr = r_clr_busy ? r_clr_addr : r_s1_base + AW'(r_s1_tslot);
    assign w_mem_wdata = r_clr_busy ? '0 : w_store;

    logic [dsc_pkg::VAL_W-1:0]         r_hist [MEM_DEPTH];
    logic signed [dsc_pkg::VAL_W-1:0]  r_rd_now;
    logic signed [dsc_pkg::VAL_W-1:0]  r_rd_next;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_hist[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_now  <= r_hist[w_addr_now];
        r_rd_next <= r_hist[w_addr_next];
    end

    logic                              r_s2_valid;
    logic                              r_s2_conn;
    logic                              r_s2_last;
    logic                              r_s2_ok;
    logic signed [dsc_pkg::WGT_W-1:0]  r_s2_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid &&
                          ((r_s1_op == dsc_pkg::OP_CONN) || (r_s1_op == dsc_pkg::OP_EMPTY));
        end
        r_s2_conn <= r_s1_op == dsc_pkg::OP_CONN;
        r_s2_last <= r_s1_last;
        r_s2_ok   <= r_s1_ok;
        r_s2_w    <= r_s1_w;
    end

    // ---------------- stage 3: products ----------------
    logic signed [dsc_pkg::VAL_W-1:0]   w_hist_now;
    logic signed [dsc_pkg::VAL_W-1:0]   w_hist_next;
    logic                               r_s3_valid;
    logic                               r_s3_conn;
    logic                               r_s3_last;
    logic signed [dsc_pkg::PROD_W-1:0]  r_s3_prod_now;
    logic signed [dsc_pkg::PROD_W-1:0]  r_s3_prod_next;

    // a source past the node count reads as zero
    assign w_hist_now  = r_s2_ok ? r_rd_now : '0;
    assign w_hist_next = r_s2_ok ? r_rd_next : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_conn      <= r_s2_conn;
        r_s3_last      <= r_s2_last;
        r_s3_prod_now  <= dsc_pkg::PROD_W'(r_s2_w) * dsc_pkg::PROD_W'(w_hist_now);
        r_s3_prod_next <= dsc_pkg::PROD_W'(r_s2_w) * dsc_pkg::PROD_W'(w_hist_next);
    end

    // ---------------- stage 4: accumulators ----------------
    logic signed [dsc_pkg::ACC_W-1:0]  r_acc_now;
    logic signed [dsc_pkg::ACC_W-1:0]  r_acc_next;
    logic signed [dsc_pkg::ACC_W-1:0]  n_acc_now;
    logic signed [dsc_pkg::ACC_W-1:0]  n_acc_next;
    logic                              r_fin_valid;
    logic signed [dsc_pkg::ACC_W-1:0]  r_fin_now;
    logic signed [dsc_pkg::ACC_W-1:0]  r_fin_next;

    assign n_acc_now  = dsc_pkg::sat_acc((dsc_pkg::ACC_W+1)'(r_acc_now) +
                                         (dsc_pkg::ACC_W+1)'(r_s3_prod_now));
    assign n_acc_next = dsc_pkg::sat_acc((dsc_pkg::ACC_W+1)'(r_acc_next) +
                                         (dsc_pkg::ACC_W+1)'(r_s3_prod_next));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_now   <= '0;
            r_acc_next  <= '0;
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= r_s3_valid && (!r_s3_conn || r_s3_last);
            if (r_s3_valid) begin
                if (r_s3_conn && !r_s3_last) begin
                    r_acc_now  <= n_acc_now;
                    r_acc_next <= n_acc_next;
                end else begin
                    r_acc_now  <= '0;
                    r_acc_next <= '0;
                end
            end
        end
        // empty row emits zeros
        r_fin_now  <= r_s3_conn ? n_acc_now : '0;
        r_fin_next <= r_s3_conn ? n_acc_next : '0;
    end

    // ---------------- stage 5: result buffer ----------------
    logic [dsc_pkg::OUT_TDATA_W-1:0]  r_of_mem [dsc_pkg::OF_DEPTH];
    logic [dsc_pkg::OF_AW-1:0]        r_of_wp;
    logic [dsc_pkg::OF_AW-1:0]        r_of_rp;
    logic [dsc_pkg::OF_CW-1:0]        r_of_cnt;
    logic                             w_out_xfer;

    assign o_m_axis_tvalid = r_of_cnt != '0;
    assign o_m_axis_tdata  = r_of_mem[r_of_rp];
    assign w_out_xfer      = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (r_fin_valid) begin
            r_of_mem[r_of_wp] <= {dsc_pkg::sat_out(r_fin_next), dsc_pkg::sat_out(r_fin_now)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wp  <= '0;
            r_of_rp  <= '0;
            r_of_cnt <= '0;
            r_pend   <= '0;
        end else begin
            if (r_fin_valid) begin
                r_of_wp <= r_of_wp + dsc_pkg::OF_AW'(1);
            end
            if (w_out_xfer) begin
                r_of_rp <= r_of_rp + dsc_pkg::OF_AW'(1);
            end
            r_of_cnt <= r_of_cnt + dsc_pkg::OF_CW'(r_fin_valid) - dsc_pkg::OF_CW'(w_out_xfer);
            r_pend   <= r_pend + dsc_pkg::OF_CW'(w_in_xfer && w_in_res)
                               - dsc_pkg::OF_CW'(w_out_xfer);
        end
    end

    // ---------------- assertions ----------------
    a_pipe_empty_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_valid && !r_s2_valid && !r_s3_valid))
        else $error("item in flight during history clear");

    a_buffer_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid |-> (r_of_cnt < dsc_pkg::OF_CW'(dsc_pkg::OF_DEPTH)))
        else $error("result buffer overflow");

    a_credit_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_of_cnt <= r_pend)
        else $error("buffered results exceed owed results");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin_valid |-> (r_acc_now == '0 && r_acc_next == '0))
        else $error("accumulators not cleared after row end");

endmodule

### dv/delayed_sparse_coupling_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the delayed sparse coupling engine.
module delayed_sparse_coupling_tb;

    localparam int NODES           = 1024;
    localparam int HIST_DEPTH      = 256;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 12;
    // history clear after reset zeroes NODES * HIST_DEPTH entries with no transfer
    localparam int WATCHDOG_CYCLES = 4 * NODES * HIST_DEPTH;
    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 40;
    localparam int SAT_TERMS       = 520;
    localparam logic [dsc_pkg::OPCODE_W-1:0]    OP_UNUSED = 2'd3;
    localparam logic signed [dsc_pkg::VAL_W-1:0] VAL_MAX  = 16'sh7FFF;
    localparam logic signed [dsc_pkg::VAL_W-1:0] VAL_MIN  = 16'sh8000;

    typedef struct packed {
        logic signed [dsc_pkg::OUT_W-1:0] later_sum;
        logic signed [dsc_pkg::OUT_W-1:0] now_sum;
    } t_coupling_sums;

    typedef struct {
        logic [dsc_pkg::OPCODE_W-1:0]     op;
        logic [dsc_pkg::TIME_W-1:0]       t;
        logic [dsc_pkg::NODE_W-1:0]       node;
        logic signed [dsc_pkg::VAL_W-1:0] sample;
        logic [dsc_pkg::NODE_W-1:0]       src;
        logic signed [dsc_pkg::WGT_W-1:0] w;
        logic [dsc_pkg::DELAY_W-1:0]      d;
        logic                             last;
    } t_coupling_item;

    class t_coupling_scoreboard;
        bit signed [dsc_pkg::VAL_W-1:0] hist_mem [NODES*HIST_DEPTH];
        longint acc_now;
        longint acc_later;
        bit heavi_mode;
        bit signed [dsc_pkg::VAL_W-1:0] thresh;
        t_coupling_sums owed_sums[$];
        int errors;
        int n_write;
        int n_conn;
        int n_empty;
        int n_unused;
        int n_results;
        int n_clamped;

        function void set_reg(logic [dsc_pkg::CFG_IDX_W-1:0] idx,
                              logic [dsc_pkg::CFG_DATA_W-1:0] val);
            if (idx == dsc_pkg::CFG_STORE_MODE) begin
                heavi_mode = val[0];
            end else begin
                thresh = val;
            end
        endfunction

        function int pending();
            return owed_sums.size();
        endfunction

        function longint clamp(longint v, int bits);
            longint hi;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint hist_read(int node, int slot);
            if (node >= NODES) return 0;
            return longint'(hist_mem[node * HIST_DEPTH + slot]);
        endfunction

        function void predict_item(logic [dsc_pkg::OPCODE_W-1:0] op,
                                   logic [dsc_pkg::IN_TDATA_W-1:0] bus, logic last);
            int slot;
            int node;
            int s0;
            int s1;
            logic signed [dsc_pkg::VAL_W-1:0] x;
            logic signed [dsc_pkg::VAL_W-1:0] v;
            logic signed [dsc_pkg::WGT_W-1:0] w;
            t_coupling_sums s;
            slot = int'(bus[dsc_pkg::TIME_LSB +: dsc_pkg::TIME_W]) % HIST_DEPTH;
            unique case (op)
                dsc_pkg::OP_WRITE: begin
                    n_write++;
                    node = int'(bus[dsc_pkg::NODE_LSB +: dsc_pkg::NODE_W]);
                    x = bus[dsc_pkg::SAMPLE_LSB +: dsc_pkg::VAL_W];
                    v = x;
                    if (heavi_mode) v = (x > thresh) ? dsc_pkg::HEAVI_ONE : '0;
                    if (node < NODES) hist_mem[node * HIST_DEPTH + slot] = v;
                end
                dsc_pkg::OP_CONN: begin
                    n_conn++;
                    node = int'(bus[dsc_pkg::SRC_LSB +: dsc_pkg::NODE_W]);
                    w = bus[dsc_pkg::WGT_LSB +: dsc_pkg::WGT_W];
                    s0 = (slot + HIST_DEPTH
                          - int'(bus[dsc_pkg::DELAY_LSB +: dsc_pkg::DELAY_W]) % HIST_DEPTH)
                         % HIST_DEPTH;
                    s1 = (s0 + 1) % HIST_DEPTH;
                    acc_now = clamp(acc_now + longint'(w) * hist_read(node, s0),
                                    dsc_pkg::ACC_W);
                    acc_later = clamp(acc_later + longint'(w) * hist_read(node, s1),
                                      dsc_pkg::ACC_W);
                    if (last) begin
                        s.now_sum = dsc_pkg::OUT_W'(clamp(acc_now, dsc_pkg::OUT_W));
                        s.later_sum = dsc_pkg::OUT_W'(clamp(acc_later, dsc_pkg::OUT_W));
                        if (s.now_sum != acc_now || s.later_sum != acc_later) n_clamped++;
                        owed_sums.push_back(s);
                        acc_now = 0;
                        acc_later = 0;
                    end
                end
                dsc_pkg::OP_EMPTY: begin
                    n_empty++;
                    acc_now = 0;
                    acc_later = 0;
                    owed_sums.push_back('0);
                end
                default: n_unused++;
            endcase
        endfunction

        function void report(string field, longint want, longint got);
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        endfunction

        function void compare_sums(logic [dsc_pkg::OUT_TDATA_W-1:0] bus);
            t_coupling_sums want;
            t_coupling_sums got;
            got = bus;
            if (owed_sums.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected no result, got now %0d later %0d",
                         $time, got.now_sum, got.later_sum);
                return;
            end
            want = owed_sums.pop_front();
            n_results++;
            if (got.now_sum !== want.now_sum) report("coupling_now", want.now_sum, got.now_sum);
            if (got.later_sum !== want.later_sum) begin
                report("coupling_next", want.later_sum, got.later_sum);
            end
        endfunction
    endclass

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic [dsc_pkg::IN_TDATA_W-1:0]     s_tdata   = '0;
    logic [dsc_pkg::OPCODE_W-1:0]       s_tuser   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tready  = 1'b0;
    logic                               cfg_valid = 1'b0;
    dsc_pkg::t_cfg_reg                  cfg_index = dsc_pkg::CFG_STORE_MODE;
    logic [dsc_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                               s_tready;
    logic                               m_tvalid;
    logic [dsc_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               cfg_ready;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int stall_cycles    = 0;
    logic [dsc_pkg::NODE_W-1:0]       node_pool [8];
    logic [dsc_pkg::TIME_W-1:0]       slot_base  = '0;
    logic signed [dsc_pkg::VAL_W-1:0] cur_thresh = '0;

    t_coupling_scoreboard sb = new();

    delayed_sparse_coupling #(
        .NODES      (NODES),
        .HIST_DEPTH (HIST_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) sb.predict_item(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.compare_sums(m_tdata);
            if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_coupling_item rand_item();
        t_coupling_item it;
        it.op     = dsc_pkg::OPCODE_W'($urandom_range(0, 3));
        it.t      = dsc_pkg::TIME_W'($urandom);
        it.node   = dsc_pkg::NODE_W'($urandom);
        it.sample = dsc_pkg::VAL_W'($urandom);
        it.src    = dsc_pkg::NODE_W'($urandom);
        it.w      = dsc_pkg::WGT_W'($urandom);
        it.d      = dsc_pkg::DELAY_W'($urandom);
        it.last   = 1'($urandom);
        return it;
    endfunction

    function automatic t_coupling_item mk(input logic [dsc_pkg::OPCODE_W-1:0] op,
                                          input int t, node, sample, src, w, d,
                                          input logic last);
        t_coupling_item it;
        it.op     = op;
        it.t      = dsc_pkg::TIME_W'(t);
        it.node   = dsc_pkg::NODE_W'(node);
        it.sample = dsc_pkg::VAL_W'(sample);
        it.src    = dsc_pkg::NODE_W'(src);
        it.w      = dsc_pkg::WGT_W'(w);
        it.d      = dsc_pkg::DELAY_W'(d);
        it.last   = last;
        return it;
    endfunction

    // full-scale values and values hugging the threshold show up often
    function automatic logic [dsc_pkg::VAL_W-1:0] rand_value();
        unique case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return dsc_pkg::VAL_W'(int'(cur_thresh) + int'($urandom_range(0, 2)) - 1);
            default: return dsc_pkg::VAL_W'($urandom);
        endcase
    endfunction

    // all tasks start and end right after a falling edge
    task automatic send_item(input t_coupling_item it);
        logic [dsc_pkg::IN_TDATA_W-1:0] bus;
        int gap;
        bus = '0;
        bus[dsc_pkg::TIME_LSB +: dsc_pkg::TIME_W]     = it.t;
        bus[dsc_pkg::NODE_LSB +: dsc_pkg::NODE_W]     = it.node;
        bus[dsc_pkg::SAMPLE_LSB +: dsc_pkg::VAL_W]    = it.sample;
        bus[dsc_pkg::SRC_LSB +: dsc_pkg::NODE_W]      = it.src;
        bus[dsc_pkg::WGT_LSB +: dsc_pkg::WGT_W]       = it.w;
        bus[dsc_pkg::DELAY_LSB +: dsc_pkg::DELAY_W]   = it.d;
        s_tdata  <= bus;
        s_tuser  <= it.op;
        s_tlast  <= it.last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // writes and open rows owe nothing, so give the pipeline time to empty
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic mode, input logic [dsc_pkg::CFG_DATA_W-1:0] thr);
        for (int r = 0; r < 2; r++) begin
            cfg_index <= (r == 0) ? dsc_pkg::CFG_STORE_MODE : dsc_pkg::CFG_THRESHOLD;
            cfg_data  <= (r == 0) ? {{(dsc_pkg::CFG_DATA_W-1){1'b0}}, mode} : thr;
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        cur_thresh = thr;
    endtask

    int idle_pace  [PHASES] = '{0, 75, 0, 9, 0};
    int stall_pace [PHASES] = '{0, 0, 75, 9, 0};

    initial begin
        t_coupling_item it;
        int k;
        int sel;
        int len;
        int sent;
        bit open_row;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        configure(1'b0, '0);

        // raw store: full-scale samples, slot wrap, output clamp, dropped partial row
        send_item(mk(dsc_pkg::OP_WRITE, 0, 0, 32767, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 255, NODES - 1, -32768, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 1, 0, -32768, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 2, 0, 32767, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_CONN, 5, 0, 0, 0, 32767, 5, 0));
        send_item(mk(dsc_pkg::OP_CONN, 255, 0, 0, NODES - 1, -32768, 0, 1));
        for (k = 0; k < 3; k++) send_item(mk(dsc_pkg::OP_CONN, 1, 0, 0, 0, -32768, 0, k == 2));
        send_item(mk(dsc_pkg::OP_CONN, 0, 0, 0, 0, 1, 255, 0));
        send_item(mk(dsc_pkg::OP_EMPTY, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_EMPTY, 255, NODES - 1, -1, NODES - 1, -1, 255, 1));
        send_item(mk(OP_UNUSED, 255, NODES - 1, -1, NODES - 1, -1, 255, 1));
        send_item(mk(dsc_pkg::OP_CONN, 0, 0, 0, NODES - 1, -1, 1, 1));
        send_item(mk(dsc_pkg::OP_CONN, 255, 0, 0, 0, 32767, 255, 1));

        // step store: equal to threshold stores zero, just above stores one
        settle();
        configure(1'b1, '0);
        send_item(mk(dsc_pkg::OP_WRITE, 10, 5, 0, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 11, 5, 1, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 12, 5, -1, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_CONN, 11, 0, 0, 5, 16384, 1, 1));
        settle();
        configure(1'b1, VAL_MIN);
        send_item(mk(dsc_pkg::OP_WRITE, 0, 6, VAL_MIN, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 1, 6, VAL_MIN + 1, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_CONN, 1, 0, 0, 6, VAL_MAX, 1, 1));

        // long row drives one accumulator into its upper and the other into its lower
        // 40-bit limit
        settle();
        configure(1'b0, '0);
        send_item(mk(dsc_pkg::OP_WRITE, 40, 100, -32768, 0, 0, 0, 0));
        send_item(mk(dsc_pkg::OP_WRITE, 41, 100, 32767, 0, 0, 0, 0));
        for (k = 0; k < SAT_TERMS; k++) begin
            send_item(mk(dsc_pkg::OP_CONN, 40, 0, 0, 100, -32768, 0, k == SAT_TERMS - 1));
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            unique case (phase)
                0: configure(1'b0, dsc_pkg::CFG_DATA_W'($urandom));
                1: configure(1'b1, VAL_MIN);
                2: configure(1'b1, dsc_pkg::CFG_DATA_W'(int'($urandom_range(0, 8191)) - 4096));
                3: configure(1'b0, dsc_pkg::CFG_DATA_W'($urandom));
                default: configure(1'b1, VAL_MAX);
            endcase
            sender_idle_pct = idle_pace[phase];
            recv_stall_pct  = stall_pace[phase];
            node_pool[0] = '0;
            node_pool[1] = dsc_pkg::NODE_W'(NODES - 1);
            for (k = 2; k < 8; k++) node_pool[k] = dsc_pkg::NODE_W'($urandom_range(0, NODES - 1));
            // one phase keeps its slot window across the ring wrap
            slot_base = (phase == 1) ? 8'd252 : 8'($urandom);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                it = rand_item();
                if (sel < 30) begin
                    it.op     = dsc_pkg::OP_WRITE;
                    it.node   = node_pool[$urandom_range(0, 7)];
                    it.t      = dsc_pkg::TIME_W'(slot_base + $urandom_range(0, 7));
                    it.sample = rand_value();
                    send_item(it);
                    sent++;
                end else if (sel < 80) begin
                    // mostly well-formed rows reading the written window
                    len = $urandom_range(1, 6);
                    open_row = ($urandom_range(0, 19) == 0);
                    for (k = 0; k < len; k++) begin
                        it = rand_item();
                        it.op = dsc_pkg::OP_CONN;
                        if ($urandom_range(0, 9) != 0) it.src = node_pool[$urandom_range(0, 7)];
                        it.d    = dsc_pkg::DELAY_W'(it.t - (slot_base + $urandom_range(0, 8)));
                        it.w    = rand_value();
                        it.last = (k == len - 1) && !open_row;
                        send_item(it);
                    end
                    sent += len;
                end else if (sel < 88) begin
                    it.op = dsc_pkg::OP_EMPTY;
                    send_item(it);
                    sent++;
                end else begin
                    send_item(it);
                    if (it.op != OP_UNUSED) sent++;
                end
                if ($urandom_range(0, 39) == 0) drain();
            end
        end

        settle();
        $display("Run covered %0d history writes, %0d connection terms, %0d empty rows,",
                 sb.n_write, sb.n_conn, sb.n_empty);
        $display("%0d unused-opcode items and %0d checked results (%0d clamped), %0d phases",
                 sb.n_unused, sb.n_results, sb.n_clamped, PHASES);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
hdl/dsc_pkg.sv
hdl/delayed_sparse_coupling.sv
dv/delayed_sparse_coupling_tb.sv
